/* rtl/camera_deadzone_follow_assert.svh */
// Assertion helpers used by the top-level camera follow module.
`ifndef CAMERA_DEADZONE_FOLLOW_ASSERT_SVH
`define CAMERA_DEADZONE_FOLLOW_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CDF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cdf_pkg.sv */
package cdf_pkg;

    // Field widths.
    localparam int POS_W    = 24;
    localparam int RATE_W   = 16;
    localparam int MS_W     = 8;
    localparam int LIMIT_W  = 23;
    localparam int FACTOR_W = 17;
    localparam int CFG_IDX_W = 3;

    // Fraction bits of lookahead time and of the blend factor.
    localparam int TIME_FRAC   = 12;
    localparam int FACTOR_FRAC = 16;

    // Default geometry, Q16.8 pixels.
    localparam int unsigned DEAD_HALF_WIDTH_D  = 16384;
    localparam int unsigned DEAD_HALF_HEIGHT_D = 12288;
    localparam int unsigned AHEAD_LIMIT_UP_D   = 16384;
    localparam int unsigned AHEAD_LIMIT_DOWN_D = 16384;

    // Blend factor is floor(rate * ms * 256 / 1000), saturated at 1.0.
    // With n = rate * ms that is floor(n * 32 / 125), done as a reciprocal
    // multiply; n at or above the saturation point always gives 1.0.
    localparam int N_W = 18;
    localparam int RECIP_W = 24;
    localparam logic [RECIP_W-1:0] FACTOR_RECIP = 24'd8589935;
    localparam int FACTOR_SHIFT = 25;
    localparam logic [RATE_W+MS_W-1:0] FACTOR_SAT_N = 24'd256000;
    localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'd65536;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD_TIME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD_LIMIT_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD_RESPONSE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_SPEED       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_MIN_X        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_MIN_Y        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_MAX_X        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_MAX_Y        = 3'd7;

    // Sequencer steps, shared by the controller and the lanes.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AHEAD_MUL,
        ST_AHEAD_CLAMP,
        ST_OFFSET_MUL,
        ST_OFFSET_ADD,
        ST_FOCUS,
        ST_DEAD_ZONE,
        ST_TARGET,
        ST_CAM_MUL,
        ST_CAM_ADD,
        ST_MERGE
    } t_step;

    // Clamp; when the bounds cross, values below lo give lo and all others give hi.
    function automatic logic signed [31:0] clamp_s(input logic signed [31:0] v,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
        logic signed [31:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* rtl/cdf_factor.sv */
module cdf_factor (
    input  logic                          i_clk,
    input  logic [cdf_pkg::RATE_W-1:0]    i_rate,
    input  logic [cdf_pkg::MS_W-1:0]      i_ms,
    output logic [cdf_pkg::FACTOR_W-1:0]  o_factor
);
    import cdf_pkg::*;

    localparam int NPROD_W = RATE_W + MS_W;
    localparam int KPROD_W = N_W + RECIP_W;

    logic [NPROD_W-1:0] n_prod;
    logic [KPROD_W-1:0] k_prod;
    logic [N_W-1:0]     r_n;
    logic               r_sat;
    logic [FACTOR_W-1:0] r_factor;

    // First stage: rate times frame time, and the saturation check.
    assign n_prod = NPROD_W'(i_rate) * NPROD_W'(i_ms);

    // Second stage: divide by the frame-time scale through the reciprocal.
    assign k_prod = KPROD_W'(r_n) * KPROD_W'(FACTOR_RECIP);

    always_ff @(posedge i_clk) begin
        r_n      <= n_prod[N_W-1:0];
        r_sat    <= (n_prod >= FACTOR_SAT_N);
        r_factor <= r_sat ? FACTOR_ONE : k_prod[FACTOR_SHIFT+FACTOR_W-1:FACTOR_SHIFT];
    end

    assign o_factor = r_factor;

endmodule

/* rtl/cdf_lane.sv */
module cdf_lane #(
    parameter int unsigned DEAD_HALF = cdf_pkg::DEAD_HALF_WIDTH_D
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cdf_pkg::t_step                      i_step,
    input  logic                                i_load,
    input  logic signed [cdf_pkg::POS_W-1:0]    i_pos,
    input  logic signed [cdf_pkg::POS_W-1:0]    i_speed,
    input  logic [cdf_pkg::RATE_W-1:0]          i_ahead_time,
    input  logic signed [cdf_pkg::POS_W-1:0]    i_ahead_lo,
    input  logic signed [cdf_pkg::POS_W-1:0]    i_ahead_hi,
    input  logic [cdf_pkg::FACTOR_W-1:0]        i_factor,
    input  logic signed [cdf_pkg::POS_W-1:0]    i_bound_min,
    input  logic signed [cdf_pkg::POS_W-1:0]    i_bound_max,
    output logic signed [cdf_pkg::POS_W-1:0]    o_cam
);
    import cdf_pkg::*;

    localparam int DIFF_W  = POS_W + 1;
    localparam int OPB_W   = RATE_W + 2;
    localparam int PROD_W  = DIFF_W + OPB_W;
    localparam int WIDE_W  = POS_W + 3;
    localparam int AHEAD_W = PROD_W - TIME_FRAC;

    logic signed [POS_W-1:0]  r_pos;
    logic signed [POS_W-1:0]  r_speed;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DIFF_W-1:0] r_focus;
    logic signed [WIDE_W-1:0] r_dz;
    logic signed [POS_W-1:0]  r_offset;
    logic signed [POS_W-1:0]  r_cam;

    logic signed [DIFF_W-1:0]  mul_a;
    logic signed [OPB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [AHEAD_W-1:0] ahead_val;
    logic signed [31:0]        ahead_cl;
    logic signed [POS_W-1:0]   ahead_raw;
    logic signed [DIFF_W-1:0]  blend_step;
    logic signed [DIFF_W-1:0]  offset_sum;
    logic signed [WIDE_W-1:0]  half;
    logic signed [WIDE_W-1:0]  cam_w;
    logic signed [WIDE_W-1:0]  focus_w;
    logic signed [WIDE_W-1:0]  dz_val;
    logic signed [31:0]        tgt_cl;
    logic signed [POS_W-1:0]   tgt;
    logic signed [DIFF_W:0]    cam_sum;
    logic signed [31:0]        cam_cl;

    // One multiplier serves the lookahead product and both blend products.
    assign mul_a = (i_step == ST_AHEAD_MUL) ? DIFF_W'(r_speed) : r_diff;
    assign mul_b = (i_step == ST_AHEAD_MUL) ? $signed({2'b00, i_ahead_time})
                                            : $signed({1'b0, i_factor});
    assign mul_p = mul_a * mul_b;

    // Raw lookahead, floored and clamped to this axis's limits.
    assign ahead_val = $signed(r_prod[PROD_W-1:TIME_FRAC]);
    assign ahead_cl  = clamp_s(32'(ahead_val), 32'(i_ahead_lo), 32'(i_ahead_hi));
    assign ahead_raw = $signed(ahead_cl[POS_W-1:0]);

    // Floored blend step; it never exceeds the distance to the goal.
    assign blend_step = $signed(r_prod[FACTOR_FRAC+DIFF_W-1:FACTOR_FRAC]);
    assign offset_sum = DIFF_W'(r_offset) + blend_step;

    // Dead-zone box around the current camera.
    assign half    = $signed(WIDE_W'(DEAD_HALF));
    assign cam_w   = WIDE_W'(r_cam);
    assign focus_w = WIDE_W'(r_focus);

    always_comb begin
        if (focus_w < cam_w - half) begin
            dz_val = focus_w + half;
        end else if (focus_w > cam_w + half) begin
            dz_val = focus_w - half;
        end else begin
            dz_val = cam_w;
        end
    end

    // Target clamped to the bounds.
    assign tgt_cl = clamp_s(32'(r_dz), 32'(i_bound_min), 32'(i_bound_max));
    assign tgt    = $signed(tgt_cl[POS_W-1:0]);

    // New camera position, clamped again.
    assign cam_sum = (DIFF_W+1)'(r_cam) + (DIFF_W+1)'(blend_step);
    assign cam_cl  = clamp_s(32'(cam_sum), 32'(i_bound_min), 32'(i_bound_max));

    // Item capture and the per-step datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pos   <= i_pos;
            r_speed <= i_speed;
        end
        case (i_step) inside
            ST_AHEAD_MUL, ST_OFFSET_MUL, ST_CAM_MUL: begin
                r_prod <= mul_p;
            end
            ST_AHEAD_CLAMP: begin
                r_diff <= DIFF_W'(ahead_raw) - DIFF_W'(r_offset);
            end
            ST_FOCUS: begin
                r_focus <= DIFF_W'(r_pos) + DIFF_W'(r_offset);
            end
            ST_DEAD_ZONE: begin
                r_dz <= dz_val;
            end
            ST_TARGET: begin
                r_diff <= DIFF_W'(tgt) - DIFF_W'(r_cam);
            end
            default: begin
            end
        endcase
    end

    // Smoothed offset and camera position, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_cam    <= '0;
        end else begin
            if (i_step == ST_OFFSET_ADD) begin
                r_offset <= $signed(offset_sum[POS_W-1:0]);
            end
            if (i_step == ST_CAM_ADD) begin
                r_cam <= $signed(cam_cl[POS_W-1:0]);
            end
        end
    end

    assign o_cam = r_cam;

endmodule

/* rtl/camera_deadzone_follow.sv */
// Dead-zone camera follow with smoothed velocity lookahead.
// Input channel: i_in_valid / o_in_stall with frame time, player position and
// player velocity, one item per rendered frame. Output channel: o_out_valid /
// i_out_stall with the new camera position, one result item per input item.
// Configuration is a write-only port: i_cfg_we, i_cfg_index, i_cfg_data, to be
// written only while no item is in flight.
// The x and y axes run in two lanes of the same design, each with one
// multiplier that is used three times per item; a shared two-stage unit
// forms both blend factors. An item takes nine sequencer steps plus a merge
// step that waits until the output register is free.
// The block takes one item at a time: o_in_stall is high from acceptance
// until the result sits in the output register.
// When the receiver stalls, the result waits in the output register; a next
// item may be accepted and run, but its result waits in the lanes until the
// output register is free.
// Reset clears the smoothed offset and the camera position to zero and loads
// the register defaults (wide-open bounds, zero rates and lookahead).
`include "camera_deadzone_follow_assert.svh"

module camera_deadzone_follow #(
    parameter int unsigned DEAD_HALF_WIDTH  = cdf_pkg::DEAD_HALF_WIDTH_D,
    parameter int unsigned DEAD_HALF_HEIGHT = cdf_pkg::DEAD_HALF_HEIGHT_D,
    parameter int unsigned AHEAD_LIMIT_UP   = cdf_pkg::AHEAD_LIMIT_UP_D,
    parameter int unsigned AHEAD_LIMIT_DOWN = cdf_pkg::AHEAD_LIMIT_DOWN_D
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [cdf_pkg::MS_W-1:0]            i_frame_ms,
    input  logic signed [cdf_pkg::POS_W-1:0]    i_player_x,
    input  logic signed [cdf_pkg::POS_W-1:0]    i_player_y,
    input  logic signed [cdf_pkg::POS_W-1:0]    i_speed_x,
    input  logic signed [cdf_pkg::POS_W-1:0]    i_speed_y,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [cdf_pkg::POS_W-1:0]    o_camera_x,
    output logic signed [cdf_pkg::POS_W-1:0]    o_camera_y,
    input  logic                                i_cfg_we,
    input  logic [cdf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cdf_pkg::POS_W-1:0]           i_cfg_data
);
    import cdf_pkg::*;

    t_step r_step;
    t_step n_step;

    logic [RATE_W-1:0]       r_lookahead_time;
    logic [LIMIT_W-1:0]      r_lookahead_limit_x;
    logic [RATE_W-1:0]       r_lookahead_response;
    logic [RATE_W-1:0]       r_follow_speed;
    logic signed [POS_W-1:0] r_bound_min_x;
    logic signed [POS_W-1:0] r_bound_min_y;
    logic signed [POS_W-1:0] r_bound_max_x;
    logic signed [POS_W-1:0] r_bound_max_y;

    logic [MS_W-1:0]         r_frame_ms;
    logic signed [POS_W-1:0] r_ahead_lo_y;
    logic signed [POS_W-1:0] r_ahead_hi_y;
    logic                    r_out_valid;
    logic signed [POS_W-1:0] r_camera_x;
    logic signed [POS_W-1:0] r_camera_y;

    logic                    in_accept;
    logic                    merge_ok;
    logic [RATE_W-1:0]       factor_rate;
    logic [FACTOR_W-1:0]     factor;
    logic signed [POS_W-1:0] limit_x;
    logic signed [POS_W-1:0] cam_x;
    logic signed [POS_W-1:0] cam_y;

    assign in_accept = i_in_valid && (r_step == ST_IDLE);
    assign merge_ok  = !r_out_valid || !i_out_stall;
    assign limit_x   = $signed({1'b0, r_lookahead_limit_x});

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookahead_time     <= '0;
            r_lookahead_limit_x  <= '0;
            r_lookahead_response <= '0;
            r_follow_speed       <= '0;
            r_bound_min_x        <= {1'b1, {(POS_W-1){1'b0}}};
            r_bound_min_y        <= {1'b1, {(POS_W-1){1'b0}}};
            r_bound_max_x        <= {1'b0, {(POS_W-1){1'b1}}};
            r_bound_max_y        <= {1'b0, {(POS_W-1){1'b1}}};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOOKAHEAD_TIME:     r_lookahead_time     <= i_cfg_data[RATE_W-1:0];
                CFG_LOOKAHEAD_LIMIT_X:  r_lookahead_limit_x  <= i_cfg_data[LIMIT_W-1:0];
                CFG_LOOKAHEAD_RESPONSE: r_lookahead_response <= i_cfg_data[RATE_W-1:0];
                CFG_FOLLOW_SPEED:       r_follow_speed       <= i_cfg_data[RATE_W-1:0];
                CFG_BOUND_MIN_X:        r_bound_min_x        <= $signed(i_cfg_data);
                CFG_BOUND_MIN_Y:        r_bound_min_y        <= $signed(i_cfg_data);
                CFG_BOUND_MAX_X:        r_bound_max_x        <= $signed(i_cfg_data);
                CFG_BOUND_MAX_Y:        r_bound_max_y        <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Item capture: frame time and the vertical lookahead window, which
    // opens upward for rising motion and downward otherwise.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_frame_ms <= i_frame_ms;
            if (i_speed_y > 0) begin
                r_ahead_lo_y <= '0;
                r_ahead_hi_y <= $signed(POS_W'(AHEAD_LIMIT_UP));
            end else begin
                r_ahead_lo_y <= -$signed(POS_W'(AHEAD_LIMIT_DOWN));
                r_ahead_hi_y <= '0;
            end
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // Sequencer next state and the input stall.
    always_comb begin
        n_step     = r_step;
        o_in_stall = 1'b1;
        unique case (r_step)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_step = ST_AHEAD_MUL;
                end
            end
            ST_AHEAD_MUL:   n_step = ST_AHEAD_CLAMP;
            ST_AHEAD_CLAMP: n_step = ST_OFFSET_MUL;
            ST_OFFSET_MUL:  n_step = ST_OFFSET_ADD;
            ST_OFFSET_ADD:  n_step = ST_FOCUS;
            ST_FOCUS:       n_step = ST_DEAD_ZONE;
            ST_DEAD_ZONE:   n_step = ST_TARGET;
            ST_TARGET:      n_step = ST_CAM_MUL;
            ST_CAM_MUL:     n_step = ST_CAM_ADD;
            ST_CAM_ADD:     n_step = ST_MERGE;
            ST_MERGE: begin
                if (merge_ok) begin
                    n_step = ST_IDLE;
                end
            end
            default: n_step = ST_IDLE;
        endcase
    end

    // The factor unit sees the lookahead rate first, then the follow rate,
    // which it keeps producing for the rest of the item.
    assign factor_rate = (r_step == ST_AHEAD_MUL) ? r_lookahead_response : r_follow_speed;

    cdf_factor u_factor (
        .i_clk    (i_clk),
        .i_rate   (factor_rate),
        .i_ms     (r_frame_ms),
        .o_factor (factor)
    );

    // Horizontal lane.
    cdf_lane #(
        .DEAD_HALF (DEAD_HALF_WIDTH)
    ) u_lane_x (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (r_step),
        .i_load       (in_accept),
        .i_pos        (i_player_x),
        .i_speed      (i_speed_x),
        .i_ahead_time (r_lookahead_time),
        .i_ahead_lo   (-limit_x),
        .i_ahead_hi   (limit_x),
        .i_factor     (factor),
        .i_bound_min  (r_bound_min_x),
        .i_bound_max  (r_bound_max_x),
        .o_cam        (cam_x)
    );

    // Vertical lane.
    cdf_lane #(
        .DEAD_HALF (DEAD_HALF_HEIGHT)
    ) u_lane_y (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (r_step),
        .i_load       (in_accept),
        .i_pos        (i_player_y),
        .i_speed      (i_speed_y),
        .i_ahead_time (r_lookahead_time),
        .i_ahead_lo   (r_ahead_lo_y),
        .i_ahead_hi   (r_ahead_hi_y),
        .i_factor     (factor),
        .i_bound_min  (r_bound_min_y),
        .i_bound_max  (r_bound_max_y),
        .o_cam        (cam_y)
    );

    // Merge both lanes into the output register once it is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_step == ST_MERGE) && merge_ok) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_step == ST_MERGE) && merge_ok) begin
            r_camera_x <= cam_x;
            r_camera_y <= cam_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_camera_x  = r_camera_x;
    assign o_camera_y  = r_camera_y;

    // An accepted item always starts at the lookahead product.
    `CDF_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_step == ST_AHEAD_MUL, "accepted item did not start the sequence")
    // A waiting result is never overwritten by the next one.
    `CDF_ASSERT_NEXT(a_merge_holds, i_clk, i_rst_n, (r_step == ST_MERGE) && r_out_valid && i_out_stall, r_step == ST_MERGE, "merge left while output was blocked")
    // A result appears only out of the merge step.
    `CDF_ASSERT_NOW(a_valid_from_merge, i_clk, i_rst_n, $rose(r_out_valid), $past(r_step == ST_MERGE), "output valid rose outside merge")

endmodule
